// File: sv/mss_pkg.sv
package mss_pkg;

  localparam int MAX_STATES     = 32;
  localparam int PROB_FRAC_BITS = 16;

  localparam int STATE_W = $clog2(MAX_STATES);
  localparam int CNT_W   = STATE_W + 1;
  localparam int PROB_W  = PROB_FRAC_BITS + 1;
  localparam int UNI_W   = PROB_FRAC_BITS;
  localparam int SUM_W   = PROB_W + STATE_W;
  localparam int TT_AW   = 2 * STATE_W;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(26);

  typedef enum logic [1:0] {
    CMD_STEP      = 2'd0,
    CMD_LOAD_PROB = 2'd1,
    CMD_LOAD_PERM = 2'd2,
    CMD_SET_STATE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic               possession_change;
    logic               passing;
    logic [UNI_W-1:0]   uniform;
    logic [STATE_W-1:0] table_to_state;
    logic [STATE_W-1:0] table_from_state;
    logic [PROB_W-1:0]  probability_value;
    logic [STATE_W-1:0] mapped_state;
  } req_t;

  typedef struct packed {
    logic [STATE_W-1:0] next_state;
    logic [STATE_W-1:0] previous_state;
    logic [PROB_W-1:0]  chosen_probability;
    logic               fell_through;
  } res_t;

endpackage

// File: sv/markov_state_sampler.sv
// Markov chain stepper. A word is taken when start is high and busy is low; each word
// gives one result word on res_o, marked by res_valid_o for a single cycle, which the
// receiver must take as it comes. Loads, set-state and plain steps answer on the next
// cycle with busy staying low. A step with relabel first reads the permutation memory
// in S_RELABEL. A step with a draw streams the current state's column out of the
// transition memory, one row per cycle, through a registered read, and stops at the
// first row whose running sum exceeds the uniform, or else at the last row in use.
// The transition memory port is read once per row.
module markov_state_sampler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  mss_pkg::req_t               req_i,
  output logic                        res_valid_o,
  output mss_pkg::res_t               res_o,
  input  logic                        cfg_we_i,
  input  logic [mss_pkg::CNT_W-1:0]   cfg_wdata_i
);
  import mss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RELABEL,
    S_SCAN
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cfg_q, cfg_d;
  logic [STATE_W-1:0] cur_q, cur_d;
  logic [STATE_W-1:0] idx_q, idx_d;
  logic               issuing_q, issuing_d;
  logic               rd_vld_q, rd_vld_d;
  logic [STATE_W-1:0] rd_row_q, rd_row_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [UNI_W-1:0]   uni_q, uni_d;
  logic               draw_q, draw_d;
  logic               res_valid_q, res_valid_d;
  res_t               res_q, res_d;

  logic [PROB_W-1:0]  tt_mem [0:(1 << TT_AW)-1];
  logic [PROB_W-1:0]  tt_rdata_q;
  logic [STATE_W-1:0] rl_mem [0:MAX_STATES-1];
  logic [STATE_W-1:0] rl_rdata_q;

  logic               accept;
  logic               tt_we, tt_re, rl_we, rl_re;
  logic [CNT_W-1:0]   cnt;
  logic [STATE_W-1:0] last_row;
  logic [SUM_W-1:0]   sum_new;
  logic               hit, finish;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // clamp the count to 1..MAX_STATES
  always_comb begin
    if (cfg_q == '0) begin
      cnt = CNT_W'(1);
    end else if (cfg_q > CNT_W'(MAX_STATES)) begin
      cnt = CNT_W'(MAX_STATES);
    end else begin
      cnt = cfg_q;
    end
  end
  assign last_row = STATE_W'(cnt - CNT_W'(1));

  assign sum_new = sum_q + SUM_W'(tt_rdata_q);
  assign hit     = SUM_W'(uni_q) < sum_new;
  assign finish  = (state_q == S_SCAN) && rd_vld_q && (hit || (rd_row_q == last_row));

  always_comb begin
    state_d     = state_q;
    cfg_d       = cfg_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    issuing_d   = issuing_q;
    sum_d       = sum_q;
    uni_d       = uni_q;
    draw_d      = draw_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    tt_we       = 1'b0;
    tt_re       = 1'b0;
    rl_we       = 1'b0;
    rl_re       = 1'b0;

    if (cfg_we_i) begin
      cfg_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.next_state         = cur_q;
          res_d.previous_state     = cur_q;
          res_d.chosen_probability = '0;
          res_d.fell_through       = 1'b0;
          uni_d                    = req_i.uniform;
          draw_d                   = req_i.passing;
          case (req_i.cmd)
            CMD_STEP: begin
              if (req_i.possession_change) begin
                rl_re   = 1'b1;
                state_d = S_RELABEL;
              end else if (req_i.passing) begin
                idx_d     = '0;
                issuing_d = 1'b1;
                sum_d     = '0;
                state_d   = S_SCAN;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            CMD_LOAD_PROB: begin
              tt_we       = 1'b1;
              res_valid_d = 1'b1;
            end
            CMD_LOAD_PERM: begin
              rl_we       = 1'b1;
              res_valid_d = 1'b1;
            end
            CMD_SET_STATE: begin
              if ({1'b0, req_i.table_to_state} < cnt) begin
                cur_d            = req_i.table_to_state;
                res_d.next_state = req_i.table_to_state;
              end
              res_valid_d = 1'b1;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_RELABEL: begin
        cur_d = rl_rdata_q;
        if (draw_q) begin
          idx_d     = '0;
          issuing_d = 1'b1;
          sum_d     = '0;
          state_d   = S_SCAN;
        end else begin
          res_d.next_state     = rl_rdata_q;
          res_d.previous_state = rl_rdata_q;
          res_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end

      S_SCAN: begin
        // keep one row read in flight ahead of the compare
        tt_re = issuing_q && !finish;
        if (tt_re) begin
          if (idx_q == last_row) begin
            issuing_d = 1'b0;
          end else begin
            idx_d = idx_q + STATE_W'(1);
          end
        end
        if (rd_vld_q) begin
          sum_d = sum_new;
        end
        if (finish) begin
          cur_d                    = rd_row_q;
          res_d.next_state         = rd_row_q;
          res_d.previous_state     = cur_q;
          res_d.chosen_probability = tt_rdata_q;
          res_d.fell_through       = !hit;
          res_valid_d              = 1'b1;
          issuing_d                = 1'b0;
          state_d                  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_vld_d = tt_re;
  assign rd_row_d = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CNT_RESET;
      cur_q       <= '0;
      idx_q       <= '0;
      issuing_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_row_q    <= '0;
      sum_q       <= '0;
      uni_q       <= '0;
      draw_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      issuing_q   <= issuing_d;
      rd_vld_q    <= rd_vld_d;
      rd_row_q    <= rd_row_d;
      sum_q       <= sum_d;
      uni_q       <= uni_d;
      draw_q      <= draw_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  // transition table: row in the upper bits, column in the lower bits
  always_ff @(posedge clk_i) begin
    if (tt_we) begin
      tt_mem[{req_i.table_to_state, req_i.table_from_state}] <= req_i.probability_value;
    end
    if (tt_re) begin
      tt_rdata_q <= tt_mem[{idx_q, cur_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rl_we) begin
      rl_mem[req_i.table_to_state] <= req_i.mapped_state;
    end
    if (rl_re) begin
      rl_rdata_q <= rl_mem[cur_q];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_quick_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.cmd != CMD_STEP) |=> res_valid_o)
    else $error("load or set-state word gave no result on the next cycle");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result strobe while still busy");

  a_column_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && $past(state_q == S_SCAN)) |-> $stable(cur_q))
    else $error("column moved during a scan");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == S_SCAN))
    else $error("table read issued outside a scan");
`endif

endmodule

// File: tb/tb_markov_state_sampler.sv
module tb_markov_state_sampler;
  import mss_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int NUM_PHASES = 8;

  typedef struct {
    bit               is_cfg;
    logic [CNT_W-1:0] cfg_value;
    req_t             word;
    bit               typed;
    res_t             want;
  } plan_row_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  req_t             word_in = '0;
  logic             res_valid;
  res_t             word_out;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // chain state as the block should hold it
  logic [STATE_W-1:0] cur_state = '0;
  logic [CNT_W-1:0]   count_reg = CNT_RESET;
  logic [PROB_W-1:0]  prob_tbl [MAX_STATES*MAX_STATES];
  logic [STATE_W-1:0] perm_tbl [MAX_STATES];

  res_t pending_moves [$];
  int   fail_count = 0;
  int   quiet_cycles = 0;

  markov_state_sampler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (word_in),
    .res_valid_o (res_valid),
    .res_o       (word_out),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int states_used();
    int n;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > MAX_STATES) n = MAX_STATES;
    return n;
  endfunction

  function automatic res_t advance_chain(req_t r);
    res_t        o;
    int          n;
    int unsigned acc;
    int          pick;
    bit          hit;
    n = states_used();
    o = '0;
    o.previous_state = cur_state;
    case (r.cmd)
      CMD_STEP: begin
        if (r.possession_change) cur_state = perm_tbl[cur_state];
        o.previous_state = cur_state;
        if (r.passing) begin
          acc = 0;
          pick = n - 1;
          hit = 1'b0;
          for (int i = 0; i < n && !hit; i++) begin
            acc += prob_tbl[i*MAX_STATES + cur_state];
            if (r.uniform < acc) begin
              pick = i;
              hit = 1'b1;
            end
          end
          o.chosen_probability = prob_tbl[pick*MAX_STATES + cur_state];
          o.fell_through = !hit;
          cur_state = STATE_W'(pick);
        end
      end
      CMD_LOAD_PROB: prob_tbl[r.table_to_state*MAX_STATES + r.table_from_state] =
          r.probability_value;
      CMD_LOAD_PERM: perm_tbl[r.table_to_state] = r.mapped_state;
      default: if (r.table_to_state < n) cur_state = r.table_to_state;
    endcase
    o.next_state = cur_state;
    return o;
  endfunction

  function automatic req_t mk_req(cmd_e c, bit relabel, bit draw, int uni, int to,
                                  int from, int prob, int mapped);
    req_t r;
    r.cmd               = c;
    r.possession_change = relabel;
    r.passing           = draw;
    r.uniform           = UNI_W'(uni);
    r.table_to_state    = STATE_W'(to);
    r.table_from_state  = STATE_W'(from);
    r.probability_value = PROB_W'(prob);
    r.mapped_state      = STATE_W'(mapped);
    return r;
  endfunction

  function automatic res_t mk_res(int nxt, int prv, int prob, bit fell);
    res_t o;
    o.next_state         = STATE_W'(nxt);
    o.previous_state     = STATE_W'(prv);
    o.chosen_probability = PROB_W'(prob);
    o.fell_through       = fell;
    return o;
  endfunction

  function automatic plan_row_t word_row(req_t r, bit typed, res_t want);
    plan_row_t p;
    p.is_cfg    = 1'b0;
    p.cfg_value = '0;
    p.word      = r;
    p.typed     = typed;
    p.want      = want;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(int v);
    plan_row_t p;
    p.is_cfg    = 1'b1;
    p.cfg_value = CNT_W'(v);
    p.word      = '0;
    p.typed     = 1'b0;
    p.want      = '0;
    return p;
  endfunction

  // skew toward small entries so draws scan deep into the column
  function automatic int rand_prob();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 0;
    if (k == 1) return 1 << PROB_FRAC_BITS;
    if (k < 6) return $urandom_range(0, 4096);
    return $urandom_range(0, 1 << PROB_FRAC_BITS);
  endfunction

  function automatic req_t rand_word();
    req_t        r;
    logic [63:0] bits;
    int          k;
    int          n;
    n = states_used();
    bits = {$urandom, $urandom};
    r = bits[$bits(req_t)-1:0];
    r.probability_value = PROB_W'(rand_prob());
    k = $urandom_range(0, 9);
    if (k == 0) r.uniform = '0;
    else if (k == 1) r.uniform = '1;
    k = $urandom_range(0, 99);
    if (k < 60) r.cmd = CMD_STEP;
    else if (k < 75) r.cmd = CMD_LOAD_PROB;
    else if (k < 85) r.cmd = CMD_LOAD_PERM;
    else begin
      r.cmd = CMD_SET_STATE;
      if ($urandom_range(0, 1) == 0) r.table_to_state = STATE_W'($urandom_range(0, n - 1));
    end
    return r;
  endfunction

  // hold start high until the word is taken, then record what it should give
  task automatic send_word(req_t r, bit typed, res_t want);
    res_t predicted;
    start   <= 1'b1;
    word_in <= r;
    do @(posedge clk_i); while (busy);
    predicted = advance_chain(r);
    pending_moves.push_back(typed ? want : predicted);
  endtask

  task automatic drain_chain();
    start <= 1'b0;
    while (pending_moves.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic set_count(logic [CNT_W-1:0] v);
    drain_chain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    count_reg = v;
    cfg_we    <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid) begin
      if (pending_moves.size() == 0) begin
        $error("unexpected result word: next_state %0d", word_out.next_state);
        fail_count++;
      end else begin
        res_t want;
        want = pending_moves.pop_front();
        if (word_out.next_state !== want.next_state) begin
          $error("next_state: expected %0d, got %0d", want.next_state, word_out.next_state);
          fail_count++;
        end
        if (word_out.previous_state !== want.previous_state) begin
          $error("previous_state: expected %0d, got %0d",
                 want.previous_state, word_out.previous_state);
          fail_count++;
        end
        if (word_out.chosen_probability !== want.chosen_probability) begin
          $error("chosen_probability: expected %0d, got %0d",
                 want.chosen_probability, word_out.chosen_probability);
          fail_count++;
        end
        if (word_out.fell_through !== want.fell_through) begin
          $error("fell_through: expected %0d, got %0d",
                 want.fell_through, word_out.fell_through);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("markov_state_sampler verification failed");
      $finish;
    end
  end

  initial begin
    plan_row_t    plan [$];
    int           cfg_plan [NUM_PHASES];
    int           idle_pct;
    int           full;
    req_t         r;

    full = 1 << PROB_FRAC_BITS;
    cfg_plan = '{63, 32, 0, 1, 26, 31, 33, 7};
    cfg_plan[NUM_PHASES-1] = $urandom_range(2, 62);

    // reset count first, then a two-state chain, then a count of zero
    plan.push_back(word_row(mk_req(CMD_STEP, 0, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_SET_STATE, 0, 0, 0, 25, 0, 0, 0), 1,
                            mk_res(25, 0, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_SET_STATE, 0, 0, 0, 26, 0, 0, 0), 1,
                            mk_res(25, 25, 0, 0)));
    plan.push_back(cfg_row(2));
    plan.push_back(word_row(mk_req(CMD_SET_STATE, 0, 0, 0, 1, 0, 0, 0), 1,
                            mk_res(1, 25, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_SET_STATE, 0, 0, 0, 31, 0, 0, 0), 1,
                            mk_res(1, 1, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_LOAD_PROB, 0, 0, 0, 0, 1, full, 0), 1,
                            mk_res(1, 1, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_LOAD_PROB, 0, 0, 0, 1, 1, 0, 0), 1,
                            mk_res(1, 1, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_STEP, 0, 1, 65535, 0, 0, 0, 0), 1,
                            mk_res(0, 1, full, 0)));
    plan.push_back(word_row(mk_req(CMD_LOAD_PROB, 0, 0, 0, 0, 0, 0, 0), 1,
                            mk_res(0, 0, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_LOAD_PROB, 0, 0, 0, 1, 0, 0, 0), 1,
                            mk_res(0, 0, 0, 0)));
    // empty column: the draw falls through to the last state in use
    plan.push_back(word_row(mk_req(CMD_STEP, 0, 1, 0, 0, 0, 0, 0), 1, mk_res(1, 0, 0, 1)));
    plan.push_back(word_row(mk_req(CMD_LOAD_PERM, 0, 0, 0, 1, 0, 0, 31), 1,
                            mk_res(1, 1, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_STEP, 1, 0, 0, 0, 0, 0, 0), 1,
                            mk_res(31, 31, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_LOAD_PROB, 0, 0, 0, 0, 31, 1, 0), 1,
                            mk_res(31, 31, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_LOAD_PROB, 0, 0, 0, 1, 31, 65535, 0), 1,
                            mk_res(31, 31, 0, 0)));
    // current state beyond the count still reads its own column
    plan.push_back(word_row(mk_req(CMD_STEP, 0, 1, 0, 0, 0, 0, 0), 1,
                            mk_res(0, 31, 1, 0)));
    plan.push_back(word_row(mk_req(CMD_LOAD_PERM, 0, 0, 0, 0, 0, 0, 1), 1,
                            mk_res(0, 0, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_STEP, 1, 1, 65535, 0, 0, 0, 0), 1,
                            mk_res(0, 1, full, 0)));
    plan.push_back(cfg_row(0));
    plan.push_back(word_row(mk_req(CMD_SET_STATE, 0, 0, 0, 1, 0, 0, 0), 1,
                            mk_res(0, 0, 0, 0)));
    plan.push_back(word_row(mk_req(CMD_STEP, 0, 1, 65535, 0, 0, 0, 0), 1,
                            mk_res(0, 0, 0, 1)));
    plan.push_back(word_row(mk_req(CMD_STEP, 1, 1, 32768, 31, 31, full, 31), 0, '0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_count(plan[i].cfg_value);
      else send_word(plan[i].word, plan[i].typed, plan[i].want);
    end

    // fill both tables so every later read hits a written entry
    for (int to = 0; to < MAX_STATES; to++) begin
      for (int from = 0; from < MAX_STATES; from++) begin
        r = rand_word();
        r.cmd = CMD_LOAD_PROB;
        r.table_to_state = STATE_W'(to);
        r.table_from_state = STATE_W'(from);
        send_word(r, 0, '0);
      end
    end
    for (int to = 0; to < MAX_STATES; to++) begin
      r = rand_word();
      r.cmd = CMD_LOAD_PERM;
      r.table_to_state = STATE_W'(to);
      send_word(r, 0, '0);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_count(CNT_W'(cfg_plan[p]));
      case (p % 4)
        1: idle_pct = 86;
        3: idle_pct = 9;
        default: idle_pct = 0;
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 60) == 0) drain_chain();
        while ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          @(posedge clk_i);
        end
        send_word(rand_word(), 0, '0);
      end
    end

    drain_chain();
    repeat (40) @(posedge clk_i);
    if (pending_moves.size() != 0) begin
      $error("%0d result words never arrived", pending_moves.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("markov_state_sampler verification clean");
    end else begin
      $display("markov_state_sampler verification failed");
    end
    $finish;
  end

endmodule
